// ===== sv/nrsh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package nrsh_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] CFG_PARALLEL_EPSILON = 2'd0;
	localparam logic [1:0] CFG_GHOST_EXTENSION  = 2'd1;

	localparam logic [31:0] TIME_ONE = 32'h0001_0000;
	localparam logic [31:0] TIME_INF = 32'hFFFF_FFFF;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFE;

	typedef struct packed {
		logic [31:0] ox;
		logic [31:0] oy;
		logic [31:0] sx;
		logic [31:0] sy;
		logic        off;
	} seg_entry_t;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] bx;
		logic [31:0] by;
		logic        clamp;
	} query_t;

	typedef struct packed {
		logic        done;
		logic [31:0] best;
		logic        found;
	} query_res_t;

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -34'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/nrsh_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface nrsh_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] point_a_x;
	logic [31:0] point_a_y;
	logic [31:0] point_b_x;
	logic [31:0] point_b_y;
	logic        segment_disabled;
	logic        clamp_to_one;

	modport source (output valid, opcode, point_a_x, point_a_y, point_b_x, point_b_y,
		segment_disabled, clamp_to_one, input ready);
	modport sink (input valid, opcode, point_a_x, point_a_y, point_b_x, point_b_y,
		segment_disabled, clamp_to_one, output ready);
endinterface
`default_nettype wire

// ===== sv/nrsh_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface nrsh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hit_time;
	logic        hit_found;
	logic        status;

	modport source (output valid, hit_time, hit_found, status, input ready);
	modport sink (input valid, hit_time, hit_found, status, output ready);
endinterface
`default_nettype wire

// ===== sv/nrsh_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nrsh_table
	import nrsh_pkg::*;
#(
	parameter int SLOTS = 256,
	localparam int AW = $clog2(SLOTS)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire seg_entry_t    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output seg_entry_t         rdata
);
	seg_entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/nrsh_stretch.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nrsh_stretch
	import nrsh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] ax,
	input  wire logic [31:0] ay,
	input  wire logic [31:0] bx,
	input  wire logic [31:0] by,
	input  wire logic [15:0] ghost,
	output logic             done,
	output logic [31:0]      org_x,
	output logic [31:0]      org_y,
	output logic [31:0]      span_x,
	output logic [31:0]      span_y
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MAG  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_ROOT = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN1 = 3'd6;
	localparam logic [2:0] S_FIN2 = 3'd7;

	logic [2:0]         state_q;
	logic [5:0]         cnt_q;
	logic signed [32:0] dx_q, dy_q;
	logic [31:0]        ax_q, ay_q, bx_q, by_q;
	logic [31:0]        mx_q, my_q;
	logic [63:0]        sqx_q, sqy_q;
	logic [63:0]        n_q, res_q, bit_q;
	logic [47:0]        qx_q, qy_q;
	logic [32:0]        rx_q, ry_q;
	logic [31:0]        ex_q, ey_q;

	logic [32:0]        magx, magy;
	logic [63:0]        trial;
	logic [31:0]        len;
	logic [33:0]        rx2, ry2;
	logic signed [33:0] offx, offy;

	assign magx  = dx_q[32] ? 33'(-dx_q) : dx_q[32:0];
	assign magy  = dy_q[32] ? 33'(-dy_q) : dy_q[32:0];
	assign trial = res_q + bit_q;
	assign len   = res_q[31:0];
	assign rx2   = {rx_q, qx_q[47]};
	assign ry2   = {ry_q, qy_q[47]};
	// zero length leaves the ends in place
	assign offx  = (len == '0) ? '0 :
		(dx_q[32] ? -$signed({18'b0, qx_q[15:0]}) : $signed({18'b0, qx_q[15:0]}));
	assign offy  = (len == '0) ? '0 :
		(dy_q[32] ? -$signed({18'b0, qy_q[15:0]}) : $signed({18'b0, qy_q[15:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_MAG;
				S_MAG:  state_q <= S_SQ;
				S_SQ:   state_q <= S_SUM;
				S_SUM:  state_q <= S_ROOT;
				S_ROOT: if (bit_q == 64'd1) state_q <= S_DIV;
				S_DIV:  if (cnt_q == 6'd47) state_q <= S_FIN1;
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ax_q <= ax; ay_q <= ay; bx_q <= bx; by_q <= by;
				dx_q <= $signed({bx[31], bx}) - $signed({ax[31], ax});
				dy_q <= $signed({by[31], by}) - $signed({ay[31], ay});
			end
			S_MAG: begin
				if (magx[32] | magx[31] | magy[32] | magy[31]) begin
					mx_q <= magx[32:1];
					my_q <= magy[32:1];
				end else begin
					mx_q <= magx[31:0];
					my_q <= magy[31:0];
				end
			end
			S_SQ: begin
				sqx_q <= mx_q * mx_q;
				sqy_q <= my_q * my_q;
			end
			S_SUM: begin
				n_q   <= sqx_q + sqy_q;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			S_ROOT: begin
				if (n_q >= trial) begin
					n_q   <= n_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				qx_q  <= 48'(mx_q * ghost);
				qy_q  <= 48'(my_q * ghost);
				rx_q  <= '0;
				ry_q  <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				if (rx2 >= {2'b0, len}) begin
					rx_q <= 33'(rx2 - {2'b0, len});
					qx_q <= {qx_q[46:0], 1'b1};
				end else begin
					rx_q <= rx2[32:0];
					qx_q <= {qx_q[46:0], 1'b0};
				end
				if (ry2 >= {2'b0, len}) begin
					ry_q <= 33'(ry2 - {2'b0, len});
					qy_q <= {qy_q[46:0], 1'b1};
				end else begin
					ry_q <= ry2[32:0];
					qy_q <= {qy_q[46:0], 1'b0};
				end
			end
			S_FIN1: begin
				org_x <= sat32($signed({{2{ax_q[31]}}, ax_q}) - offx);
				org_y <= sat32($signed({{2{ay_q[31]}}, ay_q}) - offy);
				ex_q  <= sat32($signed({{2{bx_q[31]}}, bx_q}) + offx);
				ey_q  <= sat32($signed({{2{by_q[31]}}, by_q}) + offy);
			end
			S_FIN2: begin
				span_x <= sat32($signed({{2{ex_q[31]}}, ex_q}) - $signed({{2{org_x[31]}}, org_x}));
				span_y <= sat32($signed({{2{ey_q[31]}}, ey_q}) - $signed({{2{org_y[31]}}, org_y}));
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/nrsh_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
module nrsh_eval
	import nrsh_pkg::*;
#(
	parameter int SLOTS = 256,
	localparam int AW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire query_t        qry,
	input  wire logic [31:0]   eps,
	input  wire logic [CW-1:0] count,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  wire seg_entry_t    rd_data,
	output query_res_t         res
);
	localparam logic [2:0] E_IDLE  = 3'd0;
	localparam logic [2:0] E_READ  = 3'd1;
	localparam logic [2:0] E_MUL   = 3'd2;
	localparam logic [2:0] E_CROSS = 3'd3;
	localparam logic [2:0] E_NORM  = 3'd4;
	localparam logic [2:0] E_TEST  = 3'd5;
	localparam logic [2:0] E_DIV   = 3'd6;
	localparam logic [2:0] E_CMP   = 3'd7;

	logic [2:0]         state_q;
	logic               done_q;
	logic [CW-1:0]      idx_q;
	query_t             q_q;
	logic [31:0]        eps_q;
	logic [31:0]        best_q;
	logic               found_q;
	logic               off_s1;
	logic signed [63:0] pd1_s1, pd2_s1;
	logic signed [64:0] pn1_s1, pn2_s1, pm1_s1, pm2_s1;
	logic signed [65:0] d_s2, n1_s2, n2_s2;
	logic               off_s2;
	logic signed [65:0] d_s3, n1_s3, n2_s3;
	logic               off_s3;
	logic [64:0]        rem_q;
	logic [32:0]        dvb_q;
	logic [32:0]        quo_q;
	logic [5:0]         cnt_q;
	logic [31:0]        t_q;

	logic signed [32:0] wx, wy;
	logic [64:0]        dmag;
	logic               pass;
	logic               ovf;
	logic [64:0]        rem2;
	logic [CW-1:0]      idx_nx;
	logic               last;

	assign wx = $signed({rd_data.ox[31], rd_data.ox}) - $signed({q_q.ax[31], q_q.ax});
	assign wy = $signed({rd_data.oy[31], rd_data.oy}) - $signed({q_q.ay[31], q_q.ay});
	assign dmag = d_s3[64:0];
	// D must be below 2^64, nonzero and not under the parallel tolerance
	assign pass = !off_s3 && !dmag[64] && (dmag != '0) &&
		(dmag[63:0] >= {16'b0, eps_q, 16'b0}) &&
		!n1_s3[65] && (n1_s3 != '0) &&
		!n2_s3[65] && (n2_s3 != '0) && ({1'b0, n2_s3[64:0]} < {1'b0, dmag});
	assign ovf  = {16'b0, n1_s3[64:0]} >= {dmag[63:0], 17'b0};
	assign rem2 = {rem_q[63:0], dvb_q[32]};
	assign idx_nx = idx_q + CW'(1);
	assign last = (idx_nx == count);

	assign rd_en   = (state_q == E_READ);
	assign rd_addr = idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				E_IDLE: begin
					if (start) begin
						if (count == '0) done_q <= 1'b1;
						else state_q <= E_READ;
					end
				end
				E_READ:  state_q <= E_MUL;
				E_MUL:   state_q <= E_CROSS;
				E_CROSS: state_q <= E_NORM;
				E_NORM:  state_q <= E_TEST;
				E_TEST: begin
					if (pass) begin
						state_q <= ovf ? E_CMP : E_DIV;
					end else if (last) begin
						state_q <= E_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= E_READ;
					end
				end
				E_DIV: if (cnt_q == 6'd32) state_q <= E_CMP;
				E_CMP: begin
					if (last) begin
						state_q <= E_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= E_READ;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				q_q     <= qry;
				eps_q   <= eps;
				idx_q   <= '0;
				best_q  <= qry.clamp ? TIME_ONE : TIME_INF;
				found_q <= 1'b0;
			end
			E_MUL: begin
				off_s1 <= rd_data.off;
				pd1_s1 <= $signed(q_q.bx) * $signed(rd_data.sy);
				pd2_s1 <= $signed(q_q.by) * $signed(rd_data.sx);
				pn1_s1 <= wx * $signed(rd_data.sy);
				pn2_s1 <= wy * $signed(rd_data.sx);
				pm1_s1 <= wx * $signed(q_q.by);
				pm2_s1 <= wy * $signed(q_q.bx);
			end
			E_CROSS: begin
				off_s2 <= off_s1;
				d_s2   <= $signed({{2{pd1_s1[63]}}, pd1_s1}) - $signed({{2{pd2_s1[63]}}, pd2_s1});
				n1_s2  <= $signed({pn1_s1[64], pn1_s1}) - $signed({pn2_s1[64], pn2_s1});
				n2_s2  <= $signed({pm1_s1[64], pm1_s1}) - $signed({pm2_s1[64], pm2_s1});
			end
			E_NORM: begin
				off_s3 <= off_s2;
				if (d_s2[65]) begin
					d_s3  <= -d_s2;
					n1_s3 <= -n1_s2;
					n2_s3 <= -n2_s2;
				end else begin
					d_s3  <= d_s2;
					n1_s3 <= n1_s2;
					n2_s3 <= n2_s2;
				end
			end
			E_TEST: begin
				rem_q <= {17'b0, n1_s3[64:17]};
				dvb_q <= {n1_s3[16:0], 16'b0};
				quo_q <= '0;
				cnt_q <= '0;
				t_q   <= TIME_MAX;
				if (!pass) idx_q <= idx_nx;
			end
			E_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				dvb_q <= {dvb_q[31:0], 1'b0};
				if (rem2 >= {1'b0, dmag[63:0]}) begin
					rem_q <= rem2 - {1'b0, dmag[63:0]};
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= rem2;
					quo_q <= {quo_q[31:0], 1'b0};
				end
				if (cnt_q == 6'd32) begin
					if (rem2 >= {1'b0, dmag[63:0]}) begin
						t_q <= ({quo_q[31:0], 1'b1} > {1'b0, TIME_MAX}) ? TIME_MAX
							: {quo_q[30:0], 1'b1};
					end else begin
						t_q <= ({quo_q[31:0], 1'b0} > {1'b0, TIME_MAX}) ? TIME_MAX
							: {quo_q[30:0], 1'b0};
					end
				end
			end
			E_CMP: begin
				idx_q <= idx_nx;
				if (t_q < best_q) begin
					best_q  <= t_q;
					found_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res = '{done: done_q, best: best_q, found: found_q};
endmodule
`default_nettype wire

// ===== sv/nearest_ray_segment_hit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Clear, unused opcode, full-table append: response valid in the cycle after acceptance.
// Append: the result follows the 32-step square root and the 48-step offset dividers.
// Query: each stored segment passes the read, multiply, cross, normalise and test
//   states; candidate hits add the bit-serial time divider unless the time saturates.
// One item at a time. Reset empties the table and loads register defaults.
module nearest_ray_segment_hit
	import nrsh_pkg::*;
#(
	parameter int SEGMENT_SLOTS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	nrsh_in_if.sink          request,
	nrsh_out_if.source       response,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int AW = $clog2(SEGMENT_SLOTS);
	localparam int CW = $clog2(SEGMENT_SLOTS + 1);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_APP  = 2'd1;
	localparam logic [1:0] T_QRY  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [31:0]   eps_q;
	logic [15:0]   ghost_q;
	logic          off_q;
	logic          out_valid_q;
	logic [31:0]   hit_time_q;
	logic          hit_found_q;
	logic          status_q;

	logic          accept;
	logic          app_start, qry_start;
	logic          st_done;
	logic [31:0]   st_ox, st_oy, st_sx, st_sy;
	seg_entry_t    wentry, rentry;
	query_t        qry;
	query_res_t    qres;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	assign request.ready = (state_q == T_IDLE) && (!out_valid_q || response.ready);
	assign accept    = request.valid && request.ready;
	assign app_start = accept && (request.opcode == OP_APPEND) &&
		(count_q != CW'(SEGMENT_SLOTS));
	assign qry_start = accept && (request.opcode == OP_QUERY);

	assign qry = '{ax: request.point_a_x, ay: request.point_a_y, bx: request.point_b_x,
		by: request.point_b_y, clamp: request.clamp_to_one};
	assign wentry = '{ox: st_ox, oy: st_oy, sx: st_sx, sy: st_sy, off: off_q};

	nrsh_stretch u_stretch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (app_start),
		.ax     (request.point_a_x),
		.ay     (request.point_a_y),
		.bx     (request.point_b_x),
		.by     (request.point_b_y),
		.ghost  (ghost_q),
		.done   (st_done),
		.org_x  (st_ox),
		.org_y  (st_oy),
		.span_x (st_sx),
		.span_y (st_sy)
	);

	nrsh_table #(.SLOTS(SEGMENT_SLOTS)) u_table (
		.clk   (clk),
		.we    (st_done),
		.waddr (count_q[AW-1:0]),
		.wdata (wentry),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rentry)
	);

	nrsh_eval #(.SLOTS(SEGMENT_SLOTS)) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (qry_start),
		.qry     (qry),
		.eps     (eps_q),
		.count   (count_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rentry),
		.res     (qres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q   <= 32'd66;
			ghost_q <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PARALLEL_EPSILON: eps_q   <= cfg_data;
				CFG_GHOST_EXTENSION:  ghost_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (response.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (app_start) state_q <= T_APP;
						else if (qry_start) state_q <= T_QRY;
						else begin
							out_valid_q <= 1'b1;
							if (request.opcode == OP_CLEAR) count_q <= '0;
						end
					end
				end
				T_APP: begin
					if (st_done) begin
						count_q     <= count_q + CW'(1);
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				T_QRY: begin
					if (qres.done) begin
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			off_q       <= request.segment_disabled;
			hit_time_q  <= '0;
			hit_found_q <= 1'b0;
			// refused append: table already full
			status_q    <= (request.opcode == OP_APPEND) && !app_start;
		end else if ((state_q == T_QRY) && qres.done) begin
			hit_time_q  <= qres.best;
			hit_found_q <= qres.found;
		end
	end

	assign response.valid     = out_valid_q;
	assign response.hit_time  = hit_time_q;
	assign response.hit_found = hit_found_q;
	assign response.status    = status_q;
endmodule
`default_nettype wire
